FILE: src/dtw_pkg.sv
`timescale 1ns / 1ps
package dtw_pkg;

	localparam int ClkW = 28;
	localparam int WordW = 32;
	localparam int DivStages = 32;
	localparam int IdxW = 6;
	localparam logic [ClkW-1:0] ClkReset = 28'd125000000;

	typedef enum logic [1:0] {
		CMD_INIT = 2'd0,
		CMD_SETF = 2'd1,
		CMD_PDOWN = 2'd2,
		CMD_NONE = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		PK_DATA = 2'd0,
		PK_UPDATE = 2'd1,
		PK_RESET = 2'd2,
		PK_CLOCK = 2'd3
	} pulse_kind_t;

	localparam logic [7:0] PdByte = 8'h04;

	typedef struct packed {
		logic [1:0] cmd;
		logic [4:0] phase;
		logic [WordW-1:0] word;
		logic [ClkW-1:0] rem;
	} pipe_t;

	typedef struct packed {
		logic [1:0] kind;
		logic bitv;
		logic last;
	} pulse_t;

	// one restoring step: shift in msb of word (or zero on fraction steps), quotient into lsb
	function automatic pipe_t div_step(pipe_t p, logic [ClkW-1:0] d, logic frac);
		pipe_t r;
		logic [ClkW:0] t;
		logic q;
		r = p;
		t = {p.rem, frac ? 1'b0 : p.word[WordW-1]};
		q = (t >= {1'b0, d});
		r.rem = q ? ClkW'(t - {1'b0, d}) : t[ClkW-1:0];
		r.word = {p.word[WordW-2:0], q};
		return r;
	endfunction

	function automatic logic [IdxW-1:0] seq_len(logic [1:0] cmd);
		logic [IdxW-1:0] n;
		case (cmd)
			CMD_INIT: n = 6'd3;
			CMD_SETF: n = 6'd41;
			CMD_PDOWN: n = 6'd10;
			default: n = 6'd0;
		endcase
		return n;
	endfunction

	function automatic pulse_t make_pulse(logic [1:0] cmd, logic [IdxW-1:0] idx,
			logic [WordW-1:0] word, logic [4:0] phase);
		pulse_t p;
		logic [7:0] pbyte;
		logic [IdxW-1:0] j;
		pbyte = {phase, 3'b000};
		p = '{kind: PK_DATA, bitv: 1'b0, last: 1'b0};
		j = 6'd0;
		case (cmd)
			CMD_INIT: begin
				case (idx)
					6'd0: p.kind = PK_RESET;
					6'd1: p.kind = PK_CLOCK;
					default: begin
						p.kind = PK_UPDATE;
						p.last = 1'b1;
					end
				endcase
			end
			CMD_SETF: begin
				if (idx < 6'd32) begin
					p.bitv = word[idx[4:0]];
				end else if (idx < 6'd40) begin
					j = idx - 6'd32;
					p.bitv = pbyte[j[2:0]];
				end else begin
					p.kind = PK_UPDATE;
					p.last = 1'b1;
				end
			end
			default: begin
				if (idx == 6'd0) begin
					p.kind = PK_UPDATE;
				end else if (idx < 6'd9) begin
					j = idx - 6'd1;
					p.bitv = PdByte[j[2:0]];
				end else begin
					p.kind = PK_UPDATE;
					p.last = 1'b1;
				end
			end
		endcase
		return p;
	endfunction

endpackage

FILE: src/dtw_if.sv
`timescale 1ns / 1ps
interface dtw_in_if;
	logic valid;
	logic ready;
	logic [1:0] command;
	logic [31:0] frequency_hz;
	logic [4:0] phase_step;
	modport source(output valid, command, frequency_hz, phase_step, input ready);
	modport sink(input valid, command, frequency_hz, phase_step, output ready);
endinterface

interface dtw_out_if;
	logic valid;
	logic ready;
	logic [1:0] pulse_kind;
	logic serial_bit;
	logic last;
	modport source(output valid, pulse_kind, serial_bit, last, input ready);
	modport sink(input valid, pulse_kind, serial_bit, last, output ready);
endinterface

FILE: src/dds_tuning_word_serial_loader.sv
`timescale 1ns / 1ps
// Input beat to pulse: 32 divider stages, serializer command and output registers.
// Throughput: one pulse beat per cycle while out_ch.ready is high; the serializer gives 3, 41
// or 10 beats per command; the divider pipeline takes a beat every cycle and stalls as a whole.
// Reset: arst_n asynchronous, clears valid bits and sequencer; clock register to 125 MHz.
module dds_tuning_word_serial_loader
	import dtw_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [ClkW-1:0] cfg_wdata,
	dtw_in_if.sink in_ch,
	dtw_out_if.source out_ch
);

	logic [ClkW-1:0] clk_hz_q;
	logic adv;
	logic take;
	logic [DivStages:0] v;
	pipe_t d [DivStages+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clk_hz_q <= ClkReset;
		end else if (cfg_we) begin
			clk_hz_q <= cfg_wdata;
		end
	end

	assign adv = !v[DivStages] || take;
	assign in_ch.ready = adv;
	assign v[0] = in_ch.valid;
	assign d[0] = '{cmd: in_ch.command, phase: in_ch.phase_step,
		word: in_ch.frequency_hz, rem: '0};

	for (genvar k = 0; k < DivStages; k++) begin : g_div
		dtw_div_stage u_stage (
			.clk(clk),
			.arst_n(arst_n),
			.adv(adv),
			.frac(k >= DivStages / 2),
			.divisor(clk_hz_q),
			.valid_in(v[k]),
			.data_in(d[k]),
			.valid_out(v[k+1]),
			.data_out(d[k+1])
		);
	end

	dtw_serializer u_ser (
		.clk(clk),
		.arst_n(arst_n),
		.clk_zero(clk_hz_q == '0),
		.valid_in(v[DivStages]),
		.data_in(d[DivStages]),
		.take(take),
		.out_ch(out_ch)
	);

endmodule

FILE: src/dtw_div_stage.sv
`timescale 1ns / 1ps
module dtw_div_stage
	import dtw_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic adv,
	input logic frac,
	input logic [ClkW-1:0] divisor,
	input logic valid_in,
	input pipe_t data_in,
	output logic valid_out,
	output pipe_t data_out
);

	logic valid_s1;
	pipe_t data_s1;
	pipe_t mid;

	always_comb begin
		mid = div_step(data_in, divisor, frac);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			data_s1 <= div_step(mid, divisor, frac);
		end
	end

	assign valid_out = valid_s1;
	assign data_out = data_s1;

endmodule

FILE: src/dtw_serializer.sv
`timescale 1ns / 1ps
module dtw_serializer
	import dtw_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic clk_zero,
	input logic valid_in,
	input pipe_t data_in,
	output logic take,
	dtw_out_if.source out_ch
);

	logic busy_q;
	logic [IdxW-1:0] idx_q;
	logic [1:0] cmd_q;
	logic [4:0] phase_q;
	logic [WordW-1:0] word_q;
	logic out_valid_q;
	pulse_t out_q;
	pulse_t cur;
	logic load_out;
	logic finish;

	assign load_out = !out_valid_q || out_ch.ready;
	assign cur = make_pulse(cmd_q, idx_q, word_q, phase_q);
	assign finish = busy_q && load_out && cur.last;
	assign take = !busy_q || finish;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_out) begin
				out_valid_q <= busy_q;
			end
			if (take) begin
				busy_q <= valid_in && (data_in.cmd != CMD_NONE);
				idx_q <= '0;
			end else if (busy_q && load_out) begin
				idx_q <= idx_q + 6'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_out && busy_q) begin
			out_q <= cur;
		end
		if (take) begin
			cmd_q <= data_in.cmd;
			phase_q <= data_in.phase;
			word_q <= clk_zero ? {WordW{1'b1}} : data_in.word;
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.pulse_kind = out_q.kind;
	assign out_ch.serial_bit = out_q.bitv;
	assign out_ch.last = out_q.last;

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (idx_q < seq_len(cmd_q)))
		else $error("pulse index past sequence end");
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		finish |=> (idx_q == 6'd0))
		else $error("index not rewound after last pulse");
	a_data_bit_only: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.kind != PK_DATA) |-> !out_q.bitv)
		else $error("serial bit set on non-data pulse");

endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps
module tb;
	import dtw_pkg::*;

	typedef struct packed {
		logic [1:0] kind;
		logic bitv;
		logic last;
	} beat_t;

	typedef struct {
		cmd_t cmd;
		logic [31:0] freq;
		logic [4:0] phase;
		logic chk;
		logic [31:0] word;
	} row_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [ClkW-1:0] cfg_wdata;

	dtw_in_if in_ch();
	dtw_out_if out_ch();

	dds_tuning_word_serial_loader u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	logic [ClkW-1:0] ref_clk_hz;
	beat_t pulse_q[$];
	int errors;
	int cycles;
	int hold_cycles;
	logic go_rand;
	row_t rows[$];

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 40000000) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	function automatic logic [31:0] tuning_word(logic [31:0] f, logic [ClkW-1:0] d);
		logic [63:0] num;
		if (d == 0) begin
			return 32'hFFFF_FFFF;
		end
		num = {f, 32'd0};
		return 32'(num / {36'd0, d});
	endfunction

	function automatic beat_t mk(logic [1:0] k, logic b);
		beat_t p;
		p.kind = k;
		p.bitv = b;
		p.last = 1'b0;
		return p;
	endfunction

	task automatic push_byte(logic [7:0] v);
		for (int i = 0; i < 8; i++) begin
			pulse_q.push_back(mk(PK_DATA, v[i]));
		end
	endtask

	task automatic predict(cmd_t c, logic [31:0] f, logic [4:0] ph, logic chk,
			logic [31:0] wexp);
		logic [31:0] w;
		int n0;
		n0 = pulse_q.size();
		case (c)
			CMD_INIT: begin
				pulse_q.push_back(mk(PK_RESET, 1'b0));
				pulse_q.push_back(mk(PK_CLOCK, 1'b0));
				pulse_q.push_back(mk(PK_UPDATE, 1'b0));
			end
			CMD_SETF: begin
				w = chk ? wexp : tuning_word(f, ref_clk_hz);
				for (int b = 0; b < 4; b++) begin
					push_byte(w[8*b +: 8]);
				end
				push_byte({ph, 3'b000});
				pulse_q.push_back(mk(PK_UPDATE, 1'b0));
			end
			CMD_PDOWN: begin
				pulse_q.push_back(mk(PK_UPDATE, 1'b0));
				push_byte(PdByte);
				pulse_q.push_back(mk(PK_UPDATE, 1'b0));
			end
			default: ;
		endcase
		if (pulse_q.size() > n0) begin
			pulse_q[pulse_q.size()-1].last = 1'b1;
		end
	endtask

	task automatic send(cmd_t c, logic [31:0] f, logic [4:0] ph, logic chk,
			logic [31:0] wexp);
		int gap;
		gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
		if ($urandom_range(0, 3) == 0) begin
			gap = 0;
		end
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.command <= c;
		in_ch.frequency_hz <= f;
		in_ch.phase_step <= ph;
		predict(c, f, ph, chk, wexp);
		do @(posedge clk); while (!in_ch.ready);
	endtask

	task automatic drain_and_config(logic [ClkW-1:0] v);
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (pulse_q.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		ref_clk_hz = v;
	endtask

	// sink: random stalls, and in the random phase occasional long hold-offs while the sender keeps going
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			hold_cycles <= 0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				if (pulse_q.size() == 0) begin
					$display("%0t: unexpected beat kind=%0d bit=%0d last=%0d", $time,
						out_ch.pulse_kind, out_ch.serial_bit, out_ch.last);
					errors <= errors + 1;
				end else begin
					if ({out_ch.pulse_kind, out_ch.serial_bit, out_ch.last} !== pulse_q[0]) begin
						$display("%0t: expected %0d/%0d/%0d actual %0d/%0d/%0d",
							$time, pulse_q[0].kind, pulse_q[0].bitv, pulse_q[0].last,
							out_ch.pulse_kind, out_ch.serial_bit, out_ch.last);
						errors <= errors + 1;
					end
					void'(pulse_q.pop_front());
				end
			end
			if (hold_cycles > 0) begin
				hold_cycles <= hold_cycles - 1;
				out_ch.ready <= 1'b0;
			end else if (go_rand && $urandom_range(0, 299) == 0) begin
				hold_cycles <= 400;
				out_ch.ready <= 1'b0;
			end else if ($urandom_range(0, 19) == 0) begin
				hold_cycles <= $urandom_range(10, 60);
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= !go_rand || ($urandom_range(0, 3) != 0);
			end
		end
	end

	initial begin
		logic [31:0] f;
		cmd_t c;
		int k;
		errors = 0;
		cycles = 0;
		go_rand = 1'b0;
		ref_clk_hz = ClkReset;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		in_ch.valid = 1'b0;
		in_ch.command = CMD_INIT;
		in_ch.frequency_hz = '0;
		in_ch.phase_step = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		rows.push_back('{CMD_INIT, 32'd0, 5'd0, 1'b0, 32'd0});
		rows.push_back('{CMD_SETF, 32'd0, 5'd0, 1'b1, 32'd0});
		rows.push_back('{CMD_SETF, 32'd125000000, 5'd31, 1'b1, 32'd0});
		rows.push_back('{CMD_SETF, 32'd62500000, 5'd1, 1'b1, 32'h8000_0000});
		rows.push_back('{CMD_SETF, 32'hFFFF_FFFF, 5'd16, 1'b0, 32'd0});
		rows.push_back('{CMD_SETF, 32'd10000000, 5'd5, 1'b0, 32'd0});
		rows.push_back('{CMD_PDOWN, 32'hFFFF_FFFF, 5'd31, 1'b0, 32'd0});
		rows.push_back('{CMD_NONE, 32'h1234_5678, 5'd3, 1'b0, 32'd0});
		rows.push_back('{CMD_SETF, 32'd1, 5'd0, 1'b0, 32'd0});
		rows.push_back('{CMD_INIT, 32'hFFFF_FFFF, 5'd31, 1'b0, 32'd0});
		foreach (rows[i]) begin
			send(rows[i].cmd, rows[i].freq, rows[i].phase, rows[i].chk, rows[i].word);
		end

		drain_and_config('0);
		send(CMD_SETF, 32'd5, 5'd2, 1'b1, 32'hFFFF_FFFF);
		drain_and_config(28'd1);
		send(CMD_SETF, 32'd3, 5'd0, 1'b1, 32'd0);
		send(CMD_SETF, 32'hFFFF_FFFF, 5'd0, 1'b1, 32'd0);
		drain_and_config(28'hFFF_FFFF);
		send(CMD_SETF, 32'hFFFF_FFFF, 5'd31, 1'b0, 32'd0);
		send(CMD_SETF, 32'd200000000, 5'd7, 1'b0, 32'd0);

		go_rand = 1'b1;
		for (int n = 0; n < 500; n++) begin
			if (n % 100 == 50) begin
				k = $urandom_range(0, 3);
				drain_and_config(k == 0 ? 28'd1 : k == 1 ? 28'hFFF_FFFF :
					k == 2 ? 28'(200000000) : 28'($urandom));
			end
			k = $urandom_range(0, 19);
			c = (k < 2) ? CMD_INIT : (k < 16) ? CMD_SETF : (k < 19) ? CMD_PDOWN : CMD_NONE;
			case ($urandom_range(0, 3))
				0: f = $urandom_range(0, 1000);
				1: f = $urandom_range(0, 100000000);
				default: f = $urandom;
			endcase
			send(c, f, 5'($urandom), 1'b0, 32'd0);
		end
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (pulse_q.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		if (errors == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end
endmodule

FILE: filelist.f
src/dtw_pkg.sv
src/dtw_if.sv
src/dtw_div_stage.sv
src/dtw_serializer.sv
src/dds_tuning_word_serial_loader.sv
test/tb.sv
